// ===== design/hed_pkg.sv =====
// Package for the HTML character reference decoder: payload structs, unit
// classes, reference name tables and numeric limits.
// Used by every module of the block; depends on nothing.
package hed_pkg;

  // Longest window after the '&', counting the closing ';'.
  localparam int MAX_ENTITY_LEN = 10;

  // Window counter width and the replay buffer size, which is a power of two
  // above the window length so that its pointers wrap freely.
  localparam int CNT_W     = $clog2(MAX_ENTITY_LEN + 1);
  localparam int BUF_AW    = $clog2(MAX_ENTITY_LEN + 1);
  localparam int BUF_DEPTH = 2 ** BUF_AW;

  // Queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Code units with a meaning of their own.
  localparam logic [15:0] CH_AMP  = 16'h0026;
  localparam logic [15:0] CH_SEMI = 16'h003B;
  localparam logic [15:0] CH_HASH = 16'h0023;
  localparam logic [15:0] CH_LX   = 16'h0078;
  localparam logic [15:0] CH_UX   = 16'h0058;
  localparam logic [15:0] CH_D0   = 16'h0030;
  localparam logic [15:0] CH_D9   = 16'h0039;
  localparam logic [15:0] CH_LA   = 16'h0061;
  localparam logic [15:0] CH_LF   = 16'h0066;
  localparam logic [15:0] CH_UA   = 16'h0041;
  localparam logic [15:0] CH_UF   = 16'h0046;

  // Numeric reference limits; the accumulator saturates to CODE_SAT.
  localparam int          VAL_W     = 21;
  localparam int          ACC_W     = VAL_W + 5;
  localparam logic [VAL_W-1:0] CODE_MAX  = 21'h10FFFF;
  localparam logic [VAL_W-1:0] CODE_SAT  = 21'h110000;
  localparam logic [VAL_W-1:0] SUPP_BASE = 21'h010000;
  localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
  localparam logic [5:0]  SURR_LO_TAG = 6'b110111;

  // Named references: amp, lt, gt, quot, apos, nbsp.
  localparam int NUM_NAMES    = 6;
  localparam int NAME_MAX_LEN = 4;
  localparam int NAME_IW      = $clog2(NAME_MAX_LEN);

  localparam logic [CNT_W-1:0] NAME_LEN [NUM_NAMES] = '{
    CNT_W'(3), CNT_W'(2), CNT_W'(2), CNT_W'(4), CNT_W'(4), CNT_W'(4)
  };

  localparam logic [15:0] NAME_CHARS [NUM_NAMES][NAME_MAX_LEN] = '{
    '{16'h0061, 16'h006D, 16'h0070, 16'h0000},
    '{16'h006C, 16'h0074, 16'h0000, 16'h0000},
    '{16'h0067, 16'h0074, 16'h0000, 16'h0000},
    '{16'h0071, 16'h0075, 16'h006F, 16'h0074},
    '{16'h0061, 16'h0070, 16'h006F, 16'h0073},
    '{16'h006E, 16'h0062, 16'h0073, 16'h0070}
  };

  localparam logic [15:0] NAME_CODE [NUM_NAMES] = '{
    16'h0026, 16'h003C, 16'h003E, 16'h0022, 16'h0027, 16'h00A0
  };

  // Input and output beats.
  typedef struct packed {
    logic [15:0] unit;
    logic        cue_end;
  } hed_in_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        run_last;
    logic        cue_done;
  } hed_out_t;

  // Class of one code unit, worked out once at the front.
  typedef struct packed {
    logic       is_amp;
    logic       is_semi;
    logic       is_hash;
    logic       is_x;
    logic       dec_ok;
    logic       hex_ok;
    logic [3:0] dig;
  } hed_class_t;

  // One buffered unit with its class.
  typedef struct packed {
    logic [15:0] unit;
    hed_class_t  cls;
  } hed_ent_t;

  // One queue entry: a classified unit and its end-of-cue mark.
  typedef struct packed {
    hed_ent_t ent;
    logic     cue_end;
  } hed_qitem_t;

endpackage

// ===== design/hed_front.sv =====
// Front of the decoder: takes input beats and classifies each code unit.
// Depends on hed_pkg.
module hed_front (
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hed_pkg::hed_in_t    in_data_i,
  output logic                q_valid_o,
  input  logic                q_ready_i,
  output hed_pkg::hed_qitem_t q_item_o
);

  logic [15:0]         u;
  logic                is_dec;
  logic                is_lhex;
  logic                is_uhex;
  hed_pkg::hed_class_t cls;

  // The queue sets the pace of the input channel.
  assign q_valid_o  = in_valid_i;
  assign in_ready_o = q_ready_i;

  // Classify the unit: specials, digit ranges and digit value.
  always_comb begin
    u       = in_data_i.unit;
    is_dec  = (u >= hed_pkg::CH_D0) && (u <= hed_pkg::CH_D9);
    is_lhex = (u >= hed_pkg::CH_LA) && (u <= hed_pkg::CH_LF);
    is_uhex = (u >= hed_pkg::CH_UA) && (u <= hed_pkg::CH_UF);
    cls.is_amp  = (u == hed_pkg::CH_AMP);
    cls.is_semi = (u == hed_pkg::CH_SEMI);
    cls.is_hash = (u == hed_pkg::CH_HASH);
    cls.is_x    = (u == hed_pkg::CH_LX) || (u == hed_pkg::CH_UX);
    cls.dec_ok  = is_dec;
    cls.hex_ok  = is_dec || is_lhex || is_uhex;
    priority if (is_dec) begin
      cls.dig = u[3:0];
    end else if (is_lhex || is_uhex) begin
      // Letters a-f and A-F share their low bits: 1..6 map to 10..15.
      cls.dig = 4'(u[3:0] + 4'd9);
    end else begin
      cls.dig = 4'd0;
    end
  end

  assign q_item_o.ent.unit = u;
  assign q_item_o.ent.cls  = cls;
  assign q_item_o.cue_end  = in_data_i.cue_end;

endmodule

// ===== design/hed_queue.sv =====
// Short queue of classified units between the front and the back.
// Depends on hed_pkg.
module hed_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_valid_i,
  output logic                wr_ready_o,
  input  hed_pkg::hed_qitem_t wr_item_i,
  output logic                rd_valid_o,
  input  logic                rd_ready_i,
  output hed_pkg::hed_qitem_t rd_item_o
);

  hed_pkg::hed_qitem_t           mem_q [hed_pkg::Q_DEPTH];
  logic [hed_pkg::Q_AW-1:0]      wp_q, wp_d;
  logic [hed_pkg::Q_AW-1:0]      rp_q, rp_d;
  logic [hed_pkg::Q_CW-1:0]      cnt_q, cnt_d;
  logic                          do_wr;
  logic                          do_rd;

  assign wr_ready_o = (cnt_q != hed_pkg::Q_CW'(hed_pkg::Q_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rp_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  // Pointer and fill count updates.
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wp_d = (wp_q == hed_pkg::Q_AW'(hed_pkg::Q_DEPTH - 1)) ? '0 : wp_q + hed_pkg::Q_AW'(1);
    end
    if (do_rd) begin
      rp_d = (rp_q == hed_pkg::Q_AW'(hed_pkg::Q_DEPTH - 1)) ? '0 : rp_q + hed_pkg::Q_AW'(1);
    end
    unique case ({do_wr, do_rd})
      2'b10:   cnt_d = cnt_q + hed_pkg::Q_CW'(1);
      2'b01:   cnt_d = cnt_q - hed_pkg::Q_CW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_item_i;
    end
  end

endmodule

// ===== design/hed_back.sv =====
// Back of the decoder: window engine, replay buffer, reference decoding and
// the output register. Depends on hed_pkg.
module hed_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  hed_pkg::hed_qitem_t q_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hed_pkg::hed_out_t   out_data_o
);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_LOW = 2'b10
  } back_state_e;

  // Replay buffer: the open window runs from st_q to rd_q, and units still
  // to be replayed from rd_q to wr_q.
  hed_pkg::hed_ent_t                buf_q [hed_pkg::BUF_DEPTH];
  logic [hed_pkg::BUF_AW-1:0]       rd_q, rd_d;
  logic [hed_pkg::BUF_AW-1:0]       wr_q, wr_d;
  logic [hed_pkg::BUF_AW-1:0]       st_q, st_d;
  logic                             buf_we;

  logic                             in_win_q, in_win_d;
  logic [hed_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic                             step_act_q, step_act_d;
  logic                             step_end_q, step_end_d;
  back_state_e                      state_q, state_d;

  // Incremental decoding of the window body.
  logic                             is_num_q, is_num_d;
  logic                             hex_q, hex_d;
  logic                             dig_seen_q, dig_seen_d;
  logic                             bad_q, bad_d;
  logic [hed_pkg::VAL_W-1:0]        val_q, val_d;
  logic [hed_pkg::NUM_NAMES-1:0]    name_ok_q, name_ok_d;

  // Held result, waiting to learn whether it is the last of its step.
  logic                             hold_vld_q, hold_vld_d;
  logic [15:0]                      hold_unit_q, hold_unit_d;
  logic [15:0]                      low_unit_q, low_unit_d;

  logic                             out_vld_q, out_vld_d;
  hed_pkg::hed_out_t                out_q, out_d;

  logic                             go;
  logic                             pend;
  logic                             take;
  logic                             fail;
  logic                             emit_v;
  logic [15:0]                      emit_u;
  logic                             flush;
  logic                             push;
  hed_pkg::hed_ent_t                cur;
  logic [hed_pkg::CNT_W-1:0]        cnt_inc;
  logic                             dv;
  logic [hed_pkg::ACC_W-1:0]        val_x;
  logic [hed_pkg::ACC_W-1:0]        acc;
  logic [hed_pkg::VAL_W-1:0]        val_sat;
  logic                             num_hit;
  logic [hed_pkg::VAL_W-1:0]        supp;
  logic                             name_hit;
  logic [15:0]                      name_code;

  assign go          = !out_vld_q || out_ready_i;
  assign pend        = (rd_q != wr_q);
  assign cnt_inc     = cnt_q + hed_pkg::CNT_W'(1);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // Next digit accumulation with saturation past the last code point.
  always_comb begin
    dv    = hex_q ? cur.cls.hex_ok : cur.cls.dec_ok;
    val_x = hed_pkg::ACC_W'(val_q);
    acc   = (hex_q ? (val_x << 4) : ((val_x << 3) + (val_x << 1)))
            + hed_pkg::ACC_W'(cur.cls.dig);
    val_sat = (acc > hed_pkg::ACC_W'(hed_pkg::CODE_MAX)) ? hed_pkg::CODE_SAT
                                                        : acc[hed_pkg::VAL_W-1:0];
  end

  // Outcome of a closing ';' for the body collected so far.
  always_comb begin
    num_hit = (cnt_q != '0) && is_num_q && dig_seen_q && !bad_q &&
              (val_q != '0) && (val_q <= hed_pkg::CODE_MAX);
    supp      = val_q - hed_pkg::SUPP_BASE;
    name_hit  = 1'b0;
    name_code = '0;
    for (int k = 0; k < hed_pkg::NUM_NAMES; k++) begin
      if (!name_hit && name_ok_q[k] && (hed_pkg::NAME_LEN[k] == cnt_q)) begin
        name_hit  = 1'b1;
        name_code = hed_pkg::NAME_CODE[k];
      end
    end
  end

  // Engine: one unit, one failed window, one low surrogate or one step end a cycle, while the output register can move.
  always_comb begin
    rd_d        = rd_q;
    wr_d        = wr_q;
    st_d        = st_q;
    in_win_d    = in_win_q;
    cnt_d       = cnt_q;
    step_act_d  = step_act_q;
    step_end_d  = step_end_q;
    state_d     = state_q;
    is_num_d    = is_num_q;
    hex_d       = hex_q;
    dig_seen_d  = dig_seen_q;
    bad_d       = bad_q;
    val_d       = val_q;
    name_ok_d   = name_ok_q;
    low_unit_d  = low_unit_q;
    q_ready_o   = 1'b0;
    buf_we      = 1'b0;
    cur         = buf_q[rd_q];
    take        = 1'b0;
    fail        = 1'b0;
    emit_v      = 1'b0;
    emit_u      = '0;
    flush       = 1'b0;
    if (go) begin
      unique case (state_q)
        ST_LOW: begin
          emit_v  = 1'b1;
          emit_u  = low_unit_q;
          state_d = ST_RUN;
        end
        ST_RUN: begin
          // Pick the source: replay first, then a new beat, then step end.
          priority if (pend) begin
            take = 1'b1;
          end else if (!step_act_q) begin
            if (q_valid_i) begin
              cur        = q_item_i.ent;
              take       = 1'b1;
              q_ready_o  = 1'b1;
              buf_we     = 1'b1;
              wr_d       = wr_q + hed_pkg::BUF_AW'(1);
              step_act_d = 1'b1;
              step_end_d = q_item_i.cue_end;
            end
          end else if (step_end_q && in_win_q) begin
            fail = 1'b1;
          end else begin
            flush      = 1'b1;
            step_act_d = 1'b0;
          end

          if (take) begin
            rd_d = rd_q + hed_pkg::BUF_AW'(1);
            priority if (!in_win_q) begin
              if (cur.cls.is_amp) begin
                in_win_d = 1'b1;
                cnt_d    = '0;
                st_d     = rd_q + hed_pkg::BUF_AW'(1);
              end else begin
                emit_v = 1'b1;
                emit_u = cur.unit;
              end
            end else if (cur.cls.is_semi) begin
              in_win_d = 1'b0;
              priority if (num_hit) begin
                emit_v = 1'b1;
                if (val_q < hed_pkg::SUPP_BASE) begin
                  emit_u = val_q[15:0];
                end else begin
                  emit_u     = {hed_pkg::SURR_HI_TAG, supp[19:10]};
                  low_unit_d = {hed_pkg::SURR_LO_TAG, supp[9:0]};
                  state_d    = ST_LOW;
                end
              end else if (name_hit) begin
                emit_v = 1'b1;
                emit_u = name_code;
              end else begin
                fail = 1'b1;
              end
            end else begin
              // Body unit: advance numeric and name matching.
              if (cnt_q == '0) begin
                is_num_d   = cur.cls.is_hash;
                hex_d      = 1'b0;
                dig_seen_d = 1'b0;
                bad_d      = 1'b0;
                val_d      = '0;
              end else if (is_num_q) begin
                priority if ((cnt_q == hed_pkg::CNT_W'(1)) && cur.cls.is_x) begin
                  hex_d = 1'b1;
                end else if (!dv) begin
                  bad_d = 1'b1;
                end else begin
                  val_d      = val_sat;
                  dig_seen_d = 1'b1;
                end
              end
              for (int k = 0; k < hed_pkg::NUM_NAMES; k++) begin
                name_ok_d[k] = ((cnt_q == '0) || name_ok_q[k]) &&
                               (cnt_q < hed_pkg::NAME_LEN[k]) &&
                               (cur.unit ==
                                hed_pkg::NAME_CHARS[k][cnt_q[hed_pkg::NAME_IW-1:0]]);
              end
              cnt_d = cnt_inc;
              if (cnt_inc == hed_pkg::CNT_W'(hed_pkg::MAX_ENTITY_LEN)) begin
                fail = 1'b1;
              end
            end
          end

          // A failed window gives '&' and replays its units.
          if (fail) begin
            emit_v   = 1'b1;
            emit_u   = hed_pkg::CH_AMP;
            rd_d     = st_q;
            in_win_d = 1'b0;
          end
        end
        default: begin
          state_d = ST_RUN;
        end
      endcase
    end
  end

  // Output side: a new result pushes out the held one; step end marks it last.
  always_comb begin
    hold_vld_d  = hold_vld_q;
    hold_unit_d = hold_unit_q;
    push        = 1'b0;
    out_d       = out_q;
    if (emit_v) begin
      if (hold_vld_q) begin
        push           = 1'b1;
        out_d.out_unit = hold_unit_q;
        out_d.run_last = 1'b0;
        out_d.cue_done = 1'b0;
      end
      hold_vld_d  = 1'b1;
      hold_unit_d = emit_u;
    end
    if (flush && hold_vld_q) begin
      push           = 1'b1;
      out_d.out_unit = hold_unit_q;
      out_d.run_last = 1'b1;
      out_d.cue_done = step_end_q;
      hold_vld_d     = 1'b0;
    end
    out_vld_d = push || (out_vld_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q       <= '0;
      wr_q       <= '0;
      st_q       <= '0;
      in_win_q   <= 1'b0;
      cnt_q      <= '0;
      step_act_q <= 1'b0;
      step_end_q <= 1'b0;
      state_q    <= ST_RUN;
      hold_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      rd_q       <= rd_d;
      wr_q       <= wr_d;
      st_q       <= st_d;
      in_win_q   <= in_win_d;
      cnt_q      <= cnt_d;
      step_act_q <= step_act_d;
      step_end_q <= step_end_d;
      state_q    <= state_d;
      hold_vld_q <= hold_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload and decoding registers carry no reset.
  always_ff @(posedge clk_i) begin
    is_num_q    <= is_num_d;
    hex_q       <= hex_d;
    dig_seen_q  <= dig_seen_d;
    bad_q       <= bad_d;
    val_q       <= val_d;
    name_ok_q   <= name_ok_d;
    hold_unit_q <= hold_unit_d;
    low_unit_q  <= low_unit_d;
    out_q       <= out_d;
    if (buf_we) begin
      buf_q[wr_q] <= cur;
    end
  end

  // The open window never reaches its full length between cycles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_win_q |-> (cnt_q < hed_pkg::CNT_W'(hed_pkg::MAX_ENTITY_LEN)))
    else $error("window count at or past its limit");

  // Window length matches the span between its start and the read pointer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_win_q |-> ((rd_q - st_q) == hed_pkg::BUF_AW'(cnt_q)))
    else $error("window span and count disagree");

  // Between steps nothing is left to replay and no result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_act_q |-> ((rd_q == wr_q) && !hold_vld_q))
    else $error("replay or held result left over between steps");

  // The low surrogate only follows inside an active step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOW) |-> (step_act_q && hold_vld_q))
    else $error("low surrogate pending outside a step");

endmodule

// ===== design/html_entity_decoder.sv =====
// HTML character reference decoder for UTF-16 subtitle cue text.
//
// Usage: one UTF-16 code unit per input beat on in_data_i (valid/ready),
// with cue_end set on the last unit of a cue. Result beats on out_data_o
// carry one decoded unit each; run_last marks the last result caused by an
// input beat, and cue_done the final result of a cue. A beat that opens or
// extends a character reference may give no result at all.
//
// Timing: the front classifies the unit and a two-entry queue hands it to
// the back, whose window engine handles one unit per cycle while the output
// register can move, then closes the beat in a flush step. A surrogate pair's
// low unit follows in a state of its own; a failed reference gives '&' and
// replays its units (up to 10), as does a window still open at cue end. An
// idle back sends a first result through the hold and output registers.
//
// When the receiver stalls, the result waits in the output register and the
// engine holds; the queue keeps taking input until it is full.
// Reset clears the window, the queue and all pending results; the replay
// buffer needs no clearing since only written entries are read.
// Depends on hed_pkg, hed_front, hed_queue and hed_back.
module html_entity_decoder (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  hed_pkg::hed_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output hed_pkg::hed_out_t out_data_o
);

  logic                fq_valid;
  logic                fq_ready;
  hed_pkg::hed_qitem_t fq_item;
  logic                qb_valid;
  logic                qb_ready;
  hed_pkg::hed_qitem_t qb_item;

  // Input classification.
  hed_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (fq_valid),
    .q_ready_i  (fq_ready),
    .q_item_o   (fq_item)
  );

  // Decoupling queue.
  hed_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_item_i  (fq_item),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_item_o  (qb_item)
  );

  // Window engine and result output.
  hed_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (qb_valid),
    .q_ready_o   (qb_ready),
    .q_item_i    (qb_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
